// ===== rtl/core/mrce_pkg.sv =====
// Package for the matrix row/column edit engine.
// Holds the operation codes, status codes and the sequencer state type.
// Depends on nothing.
package mrce_pkg;

   // Operation codes carried in the request word.
   localparam logic [3:0] OP_SET_SIZE = 4'd0;
   localparam logic [3:0] OP_WRITE    = 4'd1;
   localparam logic [3:0] OP_READ     = 4'd2;
   localparam logic [3:0] OP_SWAP_R   = 4'd3;
   localparam logic [3:0] OP_SWAP_C   = 4'd4;
   localparam logic [3:0] OP_DEL_R    = 4'd5;
   localparam logic [3:0] OP_DEL_C    = 4'd6;
   localparam logic [3:0] OP_INS_R    = 4'd7;
   localparam logic [3:0] OP_INS_C    = 4'd8;

   // Status codes returned in the response word.
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Sequencer states, one-hot.
   typedef enum logic [9:0] {
      S_IDLE    = 10'b00_0000_0001,
      S_CELL_RD = 10'b00_0000_0010,
      S_MOVE_RD = 10'b00_0000_0100,
      S_MOVE_WR = 10'b00_0000_1000,
      S_SWAP_RA = 10'b00_0001_0000,
      S_SWAP_RB = 10'b00_0010_0000,
      S_SWAP_WA = 10'b00_0100_0000,
      S_SWAP_WB = 10'b00_1000_0000,
      S_ZERO    = 10'b01_0000_0000,
      S_DONE    = 10'b10_0000_0000
   } state_type;

endpackage

// ===== rtl/core/matrix_row_column_edit_engine.sv =====
// Top level of the matrix row/column edit engine: cell store and its sequencer.
// Depends on mrce_pkg.
//
//   Channel   Direction  Handshake            Word
//   req_*     in         req_valid/req_stall  operation, index_a, index_b, cell_value
//   rsp_*     out        rsp_valid/rsp_stall  read_value, status, rows_now, columns_now
//
// A write and any rejected, empty or no-op operation go straight to the response; a read
// first passes through a cell read state, and any word may wait on a stalled response. A row
// or column move reads then writes each cell moved, a swap reads both cells of a pair then
// writes both, and zeroing writes one cell at a time; the sequencer makes at most one memory
// access per cycle. Reset clears only the state, the row and column counts and response valid;
// the store needs no clearing pass, since set size zeroes the window it opens. The response
// register lets a new word be taken while the previous response is stalled.
module matrix_row_column_edit_engine #(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLUMNS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_operation,
   input  logic [6:0]         req_index_a,
   input  logic [6:0]         req_index_b,
   input  logic signed [31:0] req_cell_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_read_value,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_rows_now,
   output logic [6:0]         rsp_columns_now
);

   localparam int RB    = $clog2(MAX_ROWS);
   localparam int CB    = $clog2(MAX_COLUMNS);
   localparam int IW    = (RB > CB) ? RB : CB;
   localparam int AW    = RB + CB;
   localparam int DEPTH = 1 << AW;
   localparam int MAXD  = (MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS;
   localparam int CW    = $clog2(MAXD + 1);
   localparam int XW    = ((CW > 7) ? CW : 7) + 1;
   localparam logic [XW-1:0] MRX = XW'(MAX_ROWS);
   localparam logic [XW-1:0] MCX = XW'(MAX_COLUMNS);
   localparam logic [XW-1:0] ONE = XW'(1);

   // Cell store and its registered read data.
   logic [31:0] mem [DEPTH];
   logic [31:0] rdata_ff;
   logic        rd_en;
   logic [AW-1:0] rd_addr;
   logic        wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0] wr_data;

   mrce_pkg::state_type state_ff, state_in;
   logic [CW-1:0] rows_ff, rows_in, cols_ff, cols_in;
   logic [IW-1:0] line_ff, line_in, lend_ff, lend_in, pos_ff, pos_in, pend_ff, pend_in;
   logic          rowmode_ff, rowmode_in, down_ff, down_in;
   logic [1:0]    status_ff, status_in;
   logic [31:0]   value_ff, value_in, tmp_ff, tmp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_value_ff, rsp_value_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [6:0]    rsp_rows_ff, rsp_rows_in, rsp_cols_ff, rsp_cols_in;

   logic          accept;
   logic [XW-1:0] ax, bx, rx, cx;
   logic [IW-1:0] a0, b0, src_line, dst_line;
   logic          pos_last, line_last, rsp_free;

   // Address of a cell given its line, position and orientation.
   function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] line,
                                                input logic [IW-1:0] pos,
                                                input logic rowmode);
      logic [AW-1:0] addr;
      if (rowmode) begin
         addr = {line[RB-1:0], pos[CB-1:0]};
      end else begin
         addr = {pos[RB-1:0], line[CB-1:0]};
      end
      return addr;
   endfunction

   // Memory ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != mrce_pkg::S_IDLE);
   assign ax        = XW'(req_index_a);
   assign bx        = XW'(req_index_b);
   assign rx        = XW'(rows_ff);
   assign cx        = XW'(cols_ff);
   assign a0        = IW'(req_index_a - 7'd1);
   assign b0        = IW'(req_index_b - 7'd1);
   assign src_line  = down_ff ? line_ff : IW'(line_ff + 1'b1);
   assign dst_line  = down_ff ? IW'(line_ff + 1'b1) : line_ff;
   assign pos_last  = (pos_ff == pend_ff);
   assign line_last = (line_ff == lend_ff);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Sequencer: checks a word on accept, then walks the cells it touches.
   always_comb begin
      state_in   = state_ff;
      rows_in    = rows_ff;
      cols_in    = cols_ff;
      line_in    = line_ff;
      lend_in    = lend_ff;
      pos_in     = pos_ff;
      pend_in    = pend_ff;
      rowmode_in = rowmode_ff;
      down_in    = down_ff;
      status_in  = status_ff;
      value_in   = value_ff;
      tmp_in     = tmp_ff;
      rd_en      = 1'b0;
      rd_addr    = cell_addr(src_line, pos_ff, rowmode_ff);
      wr_en      = 1'b0;
      wr_addr    = cell_addr(dst_line, pos_ff, rowmode_ff);
      wr_data    = rdata_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_rows_in   = rsp_rows_ff;
      rsp_cols_in   = rsp_cols_ff;

      unique case (state_ff)
         mrce_pkg::S_IDLE: begin
            if (accept) begin
               status_in  = mrce_pkg::ST_DONE;
               value_in   = 32'd0;
               state_in   = mrce_pkg::S_DONE;
               pos_in     = '0;
               down_in    = 1'b0;
               rowmode_in = 1'b1;
               case (req_operation) inside
                  mrce_pkg::OP_SET_SIZE: begin
                     if (ax > MRX || bx > MCX) begin
                        status_in = mrce_pkg::ST_RANGE;
                     end else begin
                        rows_in = CW'(req_index_a);
                        cols_in = CW'(req_index_b);
                        line_in = '0;
                        lend_in = a0;
                        pend_in = b0;
                        if (ax != '0 && bx != '0) begin
                           state_in = mrce_pkg::S_ZERO;
                        end
                     end
                  end
                  mrce_pkg::OP_WRITE, mrce_pkg::OP_READ: begin
                     if (ax < ONE || ax > rx || bx < ONE || bx > cx) begin
                        status_in = mrce_pkg::ST_RANGE;
                     end else if (req_operation == mrce_pkg::OP_WRITE) begin
                        wr_en   = 1'b1;
                        wr_addr = cell_addr(a0, b0, 1'b1);
                        wr_data = req_cell_value;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = cell_addr(a0, b0, 1'b1);
                        state_in = mrce_pkg::S_CELL_RD;
                     end
                  end
                  mrce_pkg::OP_SWAP_R, mrce_pkg::OP_SWAP_C: begin
                     rowmode_in = (req_operation == mrce_pkg::OP_SWAP_R);
                     line_in    = a0;
                     lend_in    = b0;
                     if (rowmode_in) begin
                        pend_in = IW'(cols_ff - 1'b1);
                        if (ax < ONE || ax > rx || bx < ONE || bx > rx) begin
                           status_in = mrce_pkg::ST_RANGE;
                        end else if (ax != bx && cx != '0) begin
                           state_in = mrce_pkg::S_SWAP_RA;
                        end
                     end else begin
                        pend_in = IW'(rows_ff - 1'b1);
                        if (ax < ONE || ax > cx || bx < ONE || bx > cx) begin
                           status_in = mrce_pkg::ST_RANGE;
                        end else if (ax != bx && rx != '0) begin
                           state_in = mrce_pkg::S_SWAP_RA;
                        end
                     end
                  end
                  mrce_pkg::OP_DEL_R: begin
                     pend_in = IW'(cols_ff - 1'b1);
                     line_in = a0;
                     lend_in = IW'(rows_ff - CW'(2));
                     if (rx == '0) begin
                        status_in = mrce_pkg::ST_FULL;
                     end else if (ax < ONE || ax > rx) begin
                        status_in = mrce_pkg::ST_RANGE;
                     end else begin
                        rows_in = rows_ff - 1'b1;
                        if (ax != rx && cx != '0) begin
                           state_in = mrce_pkg::S_MOVE_RD;
                        end
                     end
                  end
                  mrce_pkg::OP_DEL_C: begin
                     rowmode_in = 1'b0;
                     pend_in    = IW'(rows_ff - 1'b1);
                     line_in    = a0;
                     lend_in    = IW'(cols_ff - CW'(2));
                     if (cx == '0) begin
                        status_in = mrce_pkg::ST_FULL;
                     end else if (ax < ONE || ax > cx) begin
                        status_in = mrce_pkg::ST_RANGE;
                     end else begin
                        cols_in = cols_ff - 1'b1;
                        if (ax != cx && rx != '0) begin
                           state_in = mrce_pkg::S_MOVE_RD;
                        end
                     end
                  end
                  mrce_pkg::OP_INS_R: begin
                     pend_in = IW'(cols_ff - 1'b1);
                     lend_in = a0;
                     down_in = 1'b1;
                     if (rx >= MRX) begin
                        status_in = mrce_pkg::ST_FULL;
                     end else if (ax < ONE || ax > rx + ONE) begin
                        status_in = mrce_pkg::ST_RANGE;
                     end else begin
                        rows_in = rows_ff + 1'b1;
                        if (cx != '0) begin
                           if (ax == rx + ONE) begin
                              line_in  = a0;
                              state_in = mrce_pkg::S_ZERO;
                           end else begin
                              line_in  = IW'(rows_ff - 1'b1);
                              state_in = mrce_pkg::S_MOVE_RD;
                           end
                        end
                     end
                  end
                  mrce_pkg::OP_INS_C: begin
                     rowmode_in = 1'b0;
                     pend_in    = IW'(rows_ff - 1'b1);
                     lend_in    = a0;
                     down_in    = 1'b1;
                     if (cx >= MCX) begin
                        status_in = mrce_pkg::ST_FULL;
                     end else if (ax < ONE || ax > cx + ONE) begin
                        status_in = mrce_pkg::ST_RANGE;
                     end else begin
                        cols_in = cols_ff + 1'b1;
                        if (rx != '0) begin
                           if (ax == cx + ONE) begin
                              line_in  = a0;
                              state_in = mrce_pkg::S_ZERO;
                           end else begin
                              line_in  = IW'(cols_ff - 1'b1);
                              state_in = mrce_pkg::S_MOVE_RD;
                           end
                        end
                     end
                  end
                  default: begin
                     status_in = mrce_pkg::ST_DONE;
                  end
               endcase
            end
         end
         mrce_pkg::S_CELL_RD: begin
            value_in = rdata_ff;
            state_in = mrce_pkg::S_DONE;
         end
         mrce_pkg::S_MOVE_RD: begin
            rd_en    = 1'b1;
            state_in = mrce_pkg::S_MOVE_WR;
         end
         mrce_pkg::S_MOVE_WR: begin
            // Write the moved cell, then step along the line or to the next line; after the last line, zero or finish.
            wr_en    = 1'b1;
            state_in = mrce_pkg::S_MOVE_RD;
            pos_in   = IW'(pos_ff + 1'b1);
            if (pos_last) begin
               pos_in = '0;
               if (line_last) begin
                  state_in = down_ff ? mrce_pkg::S_ZERO : mrce_pkg::S_DONE;
               end else begin
                  line_in = down_ff ? IW'(line_ff - 1'b1) : IW'(line_ff + 1'b1);
               end
            end
         end
         mrce_pkg::S_SWAP_RA: begin
            rd_en    = 1'b1;
            rd_addr  = cell_addr(line_ff, pos_ff, rowmode_ff);
            state_in = mrce_pkg::S_SWAP_RB;
         end
         mrce_pkg::S_SWAP_RB: begin
            rd_en    = 1'b1;
            rd_addr  = cell_addr(lend_ff, pos_ff, rowmode_ff);
            tmp_in   = rdata_ff;
            state_in = mrce_pkg::S_SWAP_WA;
         end
         mrce_pkg::S_SWAP_WA: begin
            wr_en    = 1'b1;
            wr_addr  = cell_addr(line_ff, pos_ff, rowmode_ff);
            state_in = mrce_pkg::S_SWAP_WB;
         end
         mrce_pkg::S_SWAP_WB: begin
            wr_en    = 1'b1;
            wr_addr  = cell_addr(lend_ff, pos_ff, rowmode_ff);
            wr_data  = tmp_ff;
            pos_in   = IW'(pos_ff + 1'b1);
            state_in = pos_last ? mrce_pkg::S_DONE : mrce_pkg::S_SWAP_RA;
         end
         mrce_pkg::S_ZERO: begin
            // Zero one cell a cycle; set size sweeps several lines.
            wr_en   = 1'b1;
            wr_addr = cell_addr(line_ff, pos_ff, rowmode_ff);
            wr_data = 32'd0;
            pos_in  = IW'(pos_ff + 1'b1);
            if (pos_last) begin
               pos_in = '0;
               if (line_last) begin
                  state_in = mrce_pkg::S_DONE;
               end else begin
                  line_in = IW'(line_ff + 1'b1);
               end
            end
         end
         mrce_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = value_ff;
               rsp_status_in = status_ff;
               rsp_rows_in   = 7'(rows_ff);
               rsp_cols_in   = 7'(cols_ff);
               state_in      = mrce_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mrce_pkg::S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mrce_pkg::S_IDLE;
         rows_ff      <= '0;
         cols_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and response payload registers.
   always_ff @(posedge clock) begin
      line_ff       <= line_in;
      lend_ff       <= lend_in;
      pos_ff        <= pos_in;
      pend_ff       <= pend_in;
      rowmode_ff    <= rowmode_in;
      down_ff       <= down_in;
      status_ff     <= status_in;
      value_ff      <= value_in;
      tmp_ff        <= tmp_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rows_ff   <= rsp_rows_in;
      rsp_cols_ff   <= rsp_cols_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_rows_now    = rsp_rows_ff;
   assign rsp_columns_now = rsp_cols_ff;

endmodule
